// ===== design/scm_pkg.sv =====
package scm_pkg;

   localparam int LINE_DEPTH = 30;
   localparam int NUM_CELLS  = LINE_DEPTH - 1;
   localparam int FILL_W     = $clog2(LINE_DEPTH);

   // longest command word plus one position to see where the text ends
   localparam int SCAN_STEPS = 12;
   localparam int STEP_W     = $clog2(SCAN_STEPS);
   localparam int LEN_W      = $clog2(SCAN_STEPS + 1);

   localparam int NUM_WORDS  = 7;
   localparam int NUM_PREFIX = 3;

   localparam logic [7:0] CHAR_CR  = 8'h0d;
   localparam logic [7:0] CHAR_LF  = 8'h0a;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   localparam logic [1:0] TGT_NONE  = 2'd0;
   localparam logic [1:0] TGT_SW    = 2'd1;
   localparam logic [1:0] TGT_SERVO = 2'd2;
   localparam logic [1:0] TGT_BLIND = 2'd3;

   localparam int PFX_SW    = 0;
   localparam int PFX_SERVO = 1;
   localparam int PFX_BLIND = 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctl_type;

   typedef struct packed {
      logic       hit;
      logic       servo;
      logic [2:0] word_idx;
   } match_type;

   // command words, indexed by command code, zero padded
   localparam logic [7:0] WORD_TEXT [NUM_WORDS][SCAN_STEPS] = '{
      '{"S","W","_","S","T","A","R","T",8'h00,8'h00,8'h00,8'h00},
      '{"S","W","_","P","A","U","S","E",8'h00,8'h00,8'h00,8'h00},
      '{"S","W","_","S","T","O","P",8'h00,8'h00,8'h00,8'h00,8'h00},
      '{"S","W","_","G","E","T","_","T","I","M","E",8'h00},
      '{"B","L","I","N","D","_","C","L","O","S","E",8'h00},
      '{"B","L","I","N","D","_","H","A","L","F",8'h00,8'h00},
      '{"B","L","I","N","D","_","O","P","E","N",8'h00,8'h00}
   };

   localparam logic [LEN_W-1:0] WORD_LEN [NUM_WORDS] = '{
      LEN_W'(8), LEN_W'(8), LEN_W'(7), LEN_W'(11), LEN_W'(11), LEN_W'(10), LEN_W'(10)
   };

   localparam logic [1:0] WORD_TARGET [NUM_WORDS] = '{
      TGT_SW, TGT_SW, TGT_SW, TGT_SW, TGT_BLIND, TGT_BLIND, TGT_BLIND
   };

   localparam logic [7:0] PFX_TEXT [NUM_PREFIX][SCAN_STEPS] = '{
      '{"S","W","_",8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{"S","E","R","V","O","_",8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{"B","L","I","N","D","_",8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}
   };

   localparam logic [LEN_W-1:0] PFX_LEN [NUM_PREFIX] = '{
      LEN_W'(3), LEN_W'(6), LEN_W'(6)
   };

endpackage

// ===== design/scm_req_if.sv =====
interface scm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/scm_rsp_if.sv =====
interface scm_rsp_if;
   logic       valid;
   logic       ready;
   logic       command_valid;
   logic [1:0] target_code;
   logic [2:0] command_code;

   modport source (output valid, output command_valid, output target_code,
                   output command_code, input ready);
   modport sink (input valid, input command_valid, input target_code,
                 input command_code, output ready);
endinterface

// ===== design/scm_cell.sv =====
module scm_cell (
   input  logic       clock,
   input  logic       load,
   input  logic       shift,
   input  logic [7:0] wr_byte,
   input  logic [7:0] nbr_byte,
   output logic [7:0] cell_byte
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // shift toward cell zero during a scan, else capture a written byte
   always_comb begin
      byte_in = byte_ff;
      if (shift) begin
         byte_in = nbr_byte;
      end else if (load) begin
         byte_in = wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;

endmodule

// ===== design/scm_match.sv =====
module scm_match (
   input  logic                         clock,
   input  logic                         reset,
   input  scm_pkg::scan_ctl_type        ctl,
   input  logic [7:0]                   ch,
   input  logic [scm_pkg::STEP_W-1:0]   step_idx,
   input  logic [scm_pkg::FILL_W-1:0]   fill,
   output scm_pkg::match_type           result
);

   logic [scm_pkg::NUM_WORDS-1:0]  word_alive_ff, word_alive_in;
   logic [scm_pkg::NUM_PREFIX-1:0] pfx_alive_ff, pfx_alive_in;
   logic [scm_pkg::LEN_W-1:0]      len_ff, len_in;
   logic                           ended_ff, ended_in;
   logic                           ended_now;
   logic [scm_pkg::NUM_WORDS-1:0]  word_ok;

   always_comb begin
      word_alive_in = word_alive_ff;
      pfx_alive_in  = pfx_alive_ff;
      len_in        = len_ff;
      ended_in      = ended_ff;
      ended_now     = ended_ff || (32'(step_idx) >= 32'(fill)) || (ch == scm_pkg::CHAR_NUL);
      if (ctl.clear) begin
         word_alive_in = '1;
         pfx_alive_in  = '1;
         len_in        = '0;
         ended_in      = 1'b0;
      end else if (ctl.step) begin
         ended_in = ended_now;
         if (!ended_now) begin
            len_in = len_ff + scm_pkg::LEN_W'(1);
            for (int w = 0; w < scm_pkg::NUM_WORDS; w++) begin
               if ((32'(step_idx) < 32'(scm_pkg::WORD_LEN[w])) &&
                   (ch != scm_pkg::WORD_TEXT[w][step_idx])) begin
                  word_alive_in[w] = 1'b0;
               end
            end
            for (int p = 0; p < scm_pkg::NUM_PREFIX; p++) begin
               if ((32'(step_idx) < 32'(scm_pkg::PFX_LEN[p])) &&
                   (ch != scm_pkg::PFX_TEXT[p][step_idx])) begin
                  pfx_alive_in[p] = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ended_ff <= 1'b0;
      end else begin
         ended_ff <= ended_in;
      end
      word_alive_ff <= word_alive_in;
      pfx_alive_ff  <= pfx_alive_in;
      len_ff        <= len_in;
   end

   // exact word needs the full length, a prefix only a minimum
   always_comb begin
      result          = '0;
      result.servo    = pfx_alive_ff[scm_pkg::PFX_SERVO] &&
                        (len_ff >= scm_pkg::PFX_LEN[scm_pkg::PFX_SERVO]);
      for (int w = 0; w < scm_pkg::NUM_WORDS; w++) begin
         word_ok[w] = word_alive_ff[w] && (len_ff == scm_pkg::WORD_LEN[w]);
      end
      for (int w = scm_pkg::NUM_WORDS - 1; w >= 0; w--) begin
         if (word_ok[w]) begin
            result.hit      = 1'b1;
            result.word_idx = 3'(w);
         end
      end
   end

endmodule

// ===== design/serial_command_line_matcher_top.sv =====
// channel | dir | handshake           | payload
// req_if  | in  | valid/ready         | rx_byte[7:0]
// rsp_if  | out | valid/ready         | command_valid, target_code[1:0], command_code[2:0]
//
// an ordinary byte or an empty-line terminator has its result registered in the next cycle
// a terminator after stored text clears the matcher, then the scan and an emit step follow; the
// scan shifts the cell row one character per cycle into the serial matcher
// synchronous active-high reset clears the fill count, target, command and handshake
// one output register holds the result: a new item is taken only once the
// previous result leaves, and the emit step waits for the register to free up
module serial_command_line_matcher_top (
   input logic      clock,
   input logic      reset,
   scm_req_if.sink  req_if,
   scm_rsp_if.source rsp_if
);

   scm_pkg::state_type              state_ff, state_in;
   logic [scm_pkg::FILL_W-1:0]      fill_ff, fill_in;
   logic [scm_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [1:0]                      target_ff, target_in;
   logic [2:0]                      command_ff, command_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_cmd_valid_ff, rsp_cmd_valid_in;
   logic [1:0]                      rsp_target_ff, rsp_target_in;
   logic [2:0]                      rsp_command_ff, rsp_command_in;

   logic                            out_free;
   logic                            req_fire;
   logic                            is_term;
   logic                            store_en;
   logic                            scan_last;
   logic [scm_pkg::FILL_W-1:0]      wr_idx;
   scm_pkg::scan_ctl_type           scan_ctl;
   scm_pkg::match_type              match;
   logic [7:0]                      cell_bytes [scm_pkg::NUM_CELLS];

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign req_fire  = req_if.valid && req_if.ready;
   assign is_term   = (req_if.rx_byte == scm_pkg::CHAR_CR) ||
                      (req_if.rx_byte == scm_pkg::CHAR_LF);
   assign scan_last = (step_ff == scm_pkg::STEP_W'(scm_pkg::SCAN_STEPS - 1));

   // a full store wraps back to the first cell, dropping the older text
   assign wr_idx   = (fill_ff >= scm_pkg::FILL_W'(scm_pkg::NUM_CELLS)) ? '0 : fill_ff;
   assign store_en = req_fire && !is_term;

   // row of byte cells, cell zero feeds the matcher while scanning
   for (genvar i = 0; i < scm_pkg::NUM_CELLS; i++) begin : g_cell
      logic [7:0] nbr;
      if (i == scm_pkg::NUM_CELLS - 1) begin : g_last
         assign nbr = scm_pkg::CHAR_NUL;
      end else begin : g_mid
         assign nbr = cell_bytes[i+1];
      end
      scm_cell u_cell (
         .clock     (clock),
         .load      (store_en && (wr_idx == scm_pkg::FILL_W'(i))),
         .shift     (scan_ctl.step),
         .wr_byte   (req_if.rx_byte),
         .nbr_byte  (nbr),
         .cell_byte (cell_bytes[i])
      );
   end

   scm_match u_match (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .ch       (cell_bytes[0]),
      .step_idx (step_ff),
      .fill     (fill_ff),
      .result   (match)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scm_pkg::ST_IDLE: begin
            if (req_fire && is_term && (fill_ff != '0)) begin
               state_in = scm_pkg::ST_SCAN;
            end
         end
         scm_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = scm_pkg::ST_EMIT;
            end
         end
         scm_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = scm_pkg::ST_IDLE;
            end
         end
         default: state_in = scm_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      req_if.ready     = 1'b0;
      scan_ctl         = '0;
      fill_in          = fill_ff;
      step_in          = step_ff;
      target_in        = target_ff;
      command_in       = command_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_if.ready;
      rsp_cmd_valid_in = rsp_cmd_valid_ff;
      rsp_target_in    = rsp_target_ff;
      rsp_command_in   = rsp_command_ff;
      unique case (state_ff)
         scm_pkg::ST_IDLE: begin
            req_if.ready = out_free;
            step_in      = '0;
            if (req_fire) begin
               if (is_term && (fill_ff != '0)) begin
                  scan_ctl.clear = 1'b1;
               end else begin
                  // ordinary byte or empty line: held values right away
                  if (!is_term) begin
                     fill_in = wr_idx + scm_pkg::FILL_W'(1);
                  end
                  rsp_valid_in     = 1'b1;
                  rsp_cmd_valid_in = 1'b0;
                  rsp_target_in    = target_ff;
                  rsp_command_in   = command_ff;
               end
            end
         end
         scm_pkg::ST_SCAN: begin
            scan_ctl.step = 1'b1;
            step_in       = step_ff + scm_pkg::STEP_W'(1);
         end
         scm_pkg::ST_EMIT: begin
            if (out_free) begin
               fill_in = '0;
               if (match.hit) begin
                  target_in  = scm_pkg::WORD_TARGET[match.word_idx];
                  command_in = match.word_idx;
               end else if (match.servo) begin
                  target_in = scm_pkg::TGT_SERVO;
               end else begin
                  target_in = scm_pkg::TGT_NONE;
               end
               rsp_valid_in     = 1'b1;
               rsp_cmd_valid_in = match.hit;
               rsp_target_in    = target_in;
               rsp_command_in   = command_in;
            end
         end
         default: begin
            scan_ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scm_pkg::ST_IDLE;
         fill_ff      <= '0;
         step_ff      <= '0;
         target_ff    <= scm_pkg::TGT_NONE;
         command_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         step_ff      <= step_in;
         target_ff    <= target_in;
         command_ff   <= command_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_cmd_valid_ff <= rsp_cmd_valid_in;
      rsp_target_ff    <= rsp_target_in;
      rsp_command_ff   <= rsp_command_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.command_valid = rsp_cmd_valid_ff;
   assign rsp_if.target_code   = rsp_target_ff;
   assign rsp_if.command_code  = rsp_command_ff;

   // no new item while a line is being matched
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != scm_pkg::ST_IDLE) |-> !req_if.ready)
      else $error("item accepted during a scan");

   // fill count never passes the last cell
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= scm_pkg::FILL_W'(scm_pkg::NUM_CELLS))
      else $error("fill count out of range");

   // a reported command always comes with a stopwatch or blind target
   a_valid_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cmd_valid_ff) |->
         ((rsp_target_ff == scm_pkg::TGT_SW) || (rsp_target_ff == scm_pkg::TGT_BLIND)))
      else $error("valid command without command target");

   // scan ends after its last step
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == scm_pkg::ST_SCAN) && scan_last) |=> (state_ff == scm_pkg::ST_EMIT))
      else $error("scan did not end");

   // a finished line empties the store
   a_emit_clear: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == scm_pkg::ST_EMIT) && out_free) |=> (fill_ff == '0))
      else $error("fill count not cleared after a line");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   // command codes as the block reports them
   localparam logic [2:0] CMD_START    = 3'd0;
   localparam logic [2:0] CMD_PAUSE    = 3'd1;
   localparam logic [2:0] CMD_STOP     = 3'd2;
   localparam logic [2:0] CMD_GET_TIME = 3'd3;
   localparam logic [2:0] CMD_CLOSE    = 3'd4;
   localparam logic [2:0] CMD_HALF     = 3'd5;
   localparam logic [2:0] CMD_OPEN     = 3'd6;

   localparam int RANDOM_BYTES_END = 940;
   localparam int MAX_REPORTS      = 10;

   typedef logic [7:0] text_bytes_type[$];

   typedef struct packed {
      logic       command_valid;
      logic [1:0] target_code;
      logic [2:0] command_code;
   } line_status_type;

   logic clock;
   logic reset;

   scm_req_if req_bus ();
   scm_rsp_if rsp_bus ();

   serial_command_line_matcher_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // command words indexed by command code, as target part and action part
   string word_heads [scm_pkg::NUM_WORDS] = '{
      "SW_", "SW_", "SW_", "SW_", "BLIND_", "BLIND_", "BLIND_"
   };
   string word_tails [scm_pkg::NUM_WORDS] = '{
      "START", "PAUSE", "STOP", "GET_TIME", "CLOSE", "HALF", "OPEN"
   };

   // predicted state of the line matcher
   logic [7:0] line_text [scm_pkg::LINE_DEPTH];
   int         line_fill    = 0;
   logic [1:0] held_target  = scm_pkg::TGT_NONE;
   logic [2:0] held_command = CMD_START;

   line_status_type status_queue[$];
   int              error_count     = 0;
   int              bytes_sent      = 0;
   bit              quiet           = 1'b0;  // no random idling on either side while set
   int              rsp_hold_cycles = 0;     // long receiver hold-off, counted down below

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #10_000_000;
      $display("testbench failed");
      $finish;
   end

   function automatic void note_error(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("error at %0t: %s", $time, what);
   endfunction

   // full command word for a command code
   function automatic string command_word(input int w);
      return {word_heads[w], word_tails[w]};
   endfunction

   // true when the stored text is at least as long as p and begins with it
   function automatic bit starts_with(input int text_len, input string p);
      if (text_len < p.len())
         return 1'b0;
      for (int i = 0; i < p.len(); i++)
         if (line_text[i] != p[i])
            return 1'b0;
      return 1'b1;
   endfunction

   // exact match against the command words first..last
   function automatic bit find_word(input int text_len, input int first, input int last,
                                    output logic [2:0] code);
      string word;
      code = CMD_START;
      for (int w = first; w <= last; w++) begin
         word = command_word(w);
         if (text_len == word.len() && starts_with(text_len, word)) begin
            code = 3'(w);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // predicted status after one received byte
   function automatic line_status_type next_line_status(input logic [7:0] rx);
      line_status_type st;
      int              text_len;
      logic [2:0]      code;
      st.command_valid = 1'b0;
      if (rx == scm_pkg::CHAR_CR || rx == scm_pkg::CHAR_LF) begin
         // empty line leaves everything as it is
         if (line_fill != 0) begin
            // text stops at the first zero byte
            text_len = 0;
            while (text_len < line_fill && line_text[text_len] != scm_pkg::CHAR_NUL)
               text_len++;
            line_fill   = 0;
            held_target = scm_pkg::TGT_NONE;
            if (starts_with(text_len, "SW_")) begin
               if (find_word(text_len, CMD_START, CMD_GET_TIME, code)) begin
                  held_target      = scm_pkg::TGT_SW;
                  held_command     = code;
                  st.command_valid = 1'b1;
               end
            end else if (starts_with(text_len, "SERVO_")) begin
               // servo keeps its target but never reports a command
               held_target = scm_pkg::TGT_SERVO;
            end else if (starts_with(text_len, "BLIND_")) begin
               if (find_word(text_len, CMD_CLOSE, CMD_OPEN, code)) begin
                  held_target      = scm_pkg::TGT_BLIND;
                  held_command     = code;
                  st.command_valid = 1'b1;
               end
            end
         end
      end else begin
         // a full line wraps to the start and loses its earlier text
         if (line_fill >= scm_pkg::LINE_DEPTH - 1)
            line_fill = 0;
         line_text[line_fill] = rx;
         line_fill++;
      end
      st.target_code  = held_target;
      st.command_code = held_command;
      return st;
   endfunction

   function automatic void append_text(ref text_bytes_type q, input string s);
      for (int i = 0; i < s.len(); i++)
         q.push_back(s[i]);
   endfunction

   // upper-case letter or underscore
   function automatic logic [7:0] random_letter();
      int idx;
      idx = $urandom_range(0, 26);
      return (idx == 26) ? 8'h5f : 8'h41 + 8'(idx);
   endfunction

   // offer one item, wait for it to be taken, then predict its status
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 28) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do
         @(posedge clock);
      while (!req_bus.ready);
      status_queue.push_back(next_line_status(b));
      bytes_sent++;
   endtask

   task automatic send_line(input text_bytes_type body, input logic [7:0] term);
      foreach (body[i])
         send_byte(body[i]);
      send_byte(term);
   endtask

   // receiver side: random stalls, quiet stretches and the long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= 28);
         end
      end
   end

   // compare each status that leaves the block with the oldest prediction
   always @(posedge clock) begin
      line_status_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (status_queue.size() == 0) begin
            note_error($sformatf("unexpected item: valid %0b target %0d command %0d",
                                 rsp_bus.command_valid, rsp_bus.target_code,
                                 rsp_bus.command_code));
         end else begin
            want = status_queue.pop_front();
            if (rsp_bus.command_valid !== want.command_valid ||
                rsp_bus.target_code !== want.target_code ||
                rsp_bus.command_code !== want.command_code)
               note_error($sformatf(
                  "expected valid %0b target %0d command %0d, got valid %0b target %0d command %0d",
                  want.command_valid, want.target_code, want.command_code,
                  rsp_bus.command_valid, rsp_bus.target_code, rsp_bus.command_code));
         end
      end
   end

   // empty lines, unknown words, servo, short text, zero bytes and byte extremes
   task automatic test_odd_lines();
      text_bytes_type body;
      // terminators right after reset with nothing stored
      send_byte(scm_pkg::CHAR_CR);
      send_byte(scm_pkg::CHAR_LF);
      body = {};
      append_text(body, "SERVO_X");
      send_line(body, scm_pkg::CHAR_CR);
      body = {};
      append_text(body, "SW_JUMP");
      send_line(body, scm_pkg::CHAR_LF);
      body = {};
      append_text(body, "BLIND_UP");
      send_line(body, scm_pkg::CHAR_CR);
      body = {};
      append_text(body, "SW");
      send_line(body, scm_pkg::CHAR_LF);
      body = {};
      append_text(body, command_word(CMD_START));
      append_text(body, "X");
      send_line(body, scm_pkg::CHAR_CR);
      // text ends at the zero byte, so this is a clean stop command
      body = {};
      append_text(body, command_word(CMD_STOP));
      body.push_back(scm_pkg::CHAR_NUL);
      body.push_back(8'hff);
      send_line(body, scm_pkg::CHAR_LF);
      // leading zero byte leaves an empty text
      body = {scm_pkg::CHAR_NUL};
      append_text(body, command_word(CMD_START));
      send_line(body, scm_pkg::CHAR_CR);
      body = {8'hff};
      send_line(body, scm_pkg::CHAR_LF);
      // empty line after an unmatched line holds the cleared target
      send_byte(scm_pkg::CHAR_CR);
   endtask

   // every command word, both terminators
   task automatic test_command_words();
      text_bytes_type body;
      for (int w = 0; w < scm_pkg::NUM_WORDS; w++) begin
         body = {};
         append_text(body, command_word(w));
         send_line(body, (w % 2 == 0) ? scm_pkg::CHAR_CR : scm_pkg::CHAR_LF);
      end
   endtask

   // long lines that wrap the fill index
   task automatic test_line_wrap();
      text_bytes_type body;
      // wrap lands just before the word, which survives whole
      body = {};
      repeat (scm_pkg::LINE_DEPTH - 1) body.push_back(8'h58);
      append_text(body, command_word(CMD_OPEN));
      send_line(body, scm_pkg::CHAR_CR);
      // wrap lands inside the word and cuts its first letter off
      body = {};
      repeat (scm_pkg::LINE_DEPTH - 2) body.push_back(8'h58);
      append_text(body, command_word(CMD_START));
      send_line(body, scm_pkg::CHAR_LF);
   endtask

   // receiver holds off for a long stretch while lines keep coming
   task automatic test_output_stall();
      text_bytes_type body;
      quiet           = 1'b1;
      rsp_hold_cycles = 150;
      body = {};
      append_text(body, command_word(CMD_GET_TIME));
      send_line(body, scm_pkg::CHAR_CR);
      body = {};
      append_text(body, command_word(CMD_HALF));
      send_line(body, scm_pkg::CHAR_LF);
      quiet = 1'b0;
   endtask

   // mostly well-formed lines with random damage, plus noise
   task automatic test_random_lines();
      text_bytes_type body;
      int             kind;
      int             pick;
      int             pos;
      logic [7:0]     term;
      while (bytes_sent < RANDOM_BYTES_END) begin
         // one long stretch with no idling at all
         quiet = (bytes_sent >= 450 && bytes_sent < 600);
         body  = {};
         kind  = $urandom_range(0, 99);
         pick  = $urandom_range(0, scm_pkg::NUM_WORDS - 1);
         term  = $urandom_range(0, 1) ? scm_pkg::CHAR_CR : scm_pkg::CHAR_LF;
         if (kind < 45) begin
            append_text(body, command_word(pick));
         end else if (kind < 60) begin
            // one letter changed, the word cut short or one letter added
            append_text(body, command_word(pick));
            pos = $urandom_range(0, body.size() - 1);
            case ($urandom_range(0, 2))
               0: begin
                  body[pos] = random_letter();
               end
               1: begin
                  while (body.size() > pos + 1)
                     void'(body.pop_back());
               end
               default: begin
                  body.push_back(random_letter());
               end
            endcase
         end else if (kind < 70) begin
            append_text(body, "SERVO_");
            repeat ($urandom_range(0, 5)) body.push_back(random_letter());
         end else if (kind < 78) begin
            if ($urandom_range(0, 1))
               append_text(body, "SW_");
            else
               append_text(body, "BLIND_");
            repeat ($urandom_range(0, 6)) body.push_back(random_letter());
         end else if (kind < 86) begin
            // raw bytes, terminators and zeros among them
            repeat ($urandom_range(1, 12)) body.push_back(8'($urandom_range(0, 255)));
         end else if (kind < 92) begin
            repeat ($urandom_range(15, 40)) body.push_back(random_letter());
            append_text(body, command_word(pick));
         end else if (kind < 96) begin
            append_text(body, command_word(pick));
            body.push_back(scm_pkg::CHAR_NUL);
            repeat ($urandom_range(0, 4)) body.push_back(8'($urandom_range(0, 255)));
         end
         // anything else is an empty line
         send_line(body, term);
      end
      quiet = 1'b0;
   endtask

   initial begin
      int waited;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'h00;
      foreach (line_text[i])
         line_text[i] = scm_pkg::CHAR_NUL;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_odd_lines();
      test_command_words();
      test_line_wrap();
      test_output_stall();
      test_random_lines();

      // stop offering, let the last statuses drain
      @(negedge clock);
      req_bus.valid <= 1'b0;
      waited = 0;
      while (status_queue.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      while (status_queue.size() != 0) begin
         void'(status_queue.pop_front());
         note_error("status never arrived");
      end

      if (error_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
